// File: hw/rtl/sspg_pkg.sv
// shared types, constants and sine table of the sine sweep pwm generator
`timescale 1ns / 1ps
`default_nettype none
package sspg_pkg;

	// field and counter widths
	localparam int TIME_W     = 24;
	localparam int PERIOD_W   = 20;
	localparam int FREQ_W     = 16;
	localparam int RATE_W     = 8;
	localparam int CMP_W      = 7;
	localparam int LIMIT_W    = 18;
	localparam int ROM_DEPTH  = 64;
	localparam int ROM_IDX_W  = 6;
	localparam int SAMPLE_W   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int FSTEP_W    = FREQ_W + 2;

	// arithmetic constants
	localparam logic [TIME_W-1:0]   TIME_MAX    = '1;
	localparam logic [PERIOD_W-1:0] DIVIDEND    = PERIOD_W'(1000000);
	localparam logic [LIMIT_W-1:0]  US_PER_MS   = LIMIT_W'(1000);
	localparam logic [SAMPLE_W-1:0] HALF_SCALE  = SAMPLE_W'(127);
	localparam logic [SAMPLE_W-1:0] FULL_SCALE  = SAMPLE_W'(255);
	localparam logic [CMP_W-1:0]    CMP_TOP     = CMP_W'(127);

	// register reset values
	localparam logic [FREQ_W-1:0]   FREQ_START_RST = FREQ_W'(30);
	localparam logic [FREQ_W-1:0]   FREQ_END_RST   = FREQ_W'(1000);
	localparam logic [FREQ_W-1:0]   FREQ_STEP_RST  = FREQ_W'(19);
	localparam logic [LIMIT_W-1:0]  LIMIT_RST      = LIMIT_W'(100000);
	localparam logic [RATE_W-1:0]   TICK_RST       = RATE_W'(25);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FREQ_START      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_FREQ_END        = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_FREQ_STEP       = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_INTERVAL = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_HALF_US    = CFG_IDX_W'(4);

	// floor(255*(sin+1)/2) over one cycle
	localparam logic [SAMPLE_W-1:0] SINE_ROM [ROM_DEPTH] = '{
		8'd127, 8'd139, 8'd152, 8'd164, 8'd176, 8'd187, 8'd198, 8'd208,
		8'd217, 8'd226, 8'd233, 8'd239, 8'd245, 8'd249, 8'd252, 8'd254,
		8'd255, 8'd254, 8'd252, 8'd249, 8'd245, 8'd239, 8'd233, 8'd226,
		8'd217, 8'd208, 8'd198, 8'd187, 8'd176, 8'd164, 8'd152, 8'd139,
		8'd127, 8'd115, 8'd102, 8'd90,  8'd78,  8'd67,  8'd56,  8'd46,
		8'd37,  8'd28,  8'd21,  8'd15,  8'd9,   8'd5,   8'd2,   8'd0,
		8'd0,   8'd0,   8'd2,   8'd5,   8'd9,   8'd15,  8'd21,  8'd28,
		8'd37,  8'd46,  8'd56,  8'd67,  8'd78,  8'd90,  8'd102, 8'd115
	};

	// channel payloads
	typedef struct packed {
		logic tick;
	} tick_t;

	typedef struct packed {
		logic [CMP_W-1:0]  pwm_positive_compare;
		logic [CMP_W-1:0]  pwm_negative_compare;
		logic              sample_updated;
		logic [FREQ_W-1:0] current_frequency;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_t;

	// divider control and status
	typedef struct packed {
		logic              start;
		logic [FREQ_W-1:0] freq;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [PERIOD_W-1:0] quotient;
	} div_rsp_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POINT,
		ST_SWEEP,
		ST_STEP,
		ST_DIV,
		ST_SPAN,
		ST_PUSH
	} seq_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_LOAD,
		DV_RUN
	} div_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/sspg_stream_if.sv
// valid/ready channel carrying one payload per transaction
`timescale 1ns / 1ps
`default_nettype none
interface sspg_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sine_sweep_pwm_generator.sv
// Sine sweep PWM generator: tick in, one compare pair per tick out.
// Channels: item (sink, payload tick), result (source, payload with the two
// PWM compare values, sample_updated and current_frequency) and cfg (sink,
// register index and write data, always ready). Registers: 0 freq_start,
// 1 freq_end, 2 freq_step, 3 update_interval_ms, 4 tick_half_us.
// Each accepted tick with the tick bit set advances the cycle clock; when it
// reaches the next point instant the next sine sample is emitted. After POINTS
// samples the sweep time grows and, once the update interval has passed, the
// frequency steps and the point period is recomputed by a bit-serial divider,
// one quotient bit per cycle over 20 bits.
// A tick is accepted in IDLE and passes through POINT, then SWEEP at the end of a
// sine cycle and STEP, DIV and SPAN on a frequency update, before PUSH loads the
// result. One tick is processed at a time, so the next one is accepted only after
// PUSH has loaded the result of the last.
// A finished result sits in an output register; the next tick is accepted
// while it waits, and its own result is held until the receiver takes the
// earlier one. Reset clears all counters, loads default registers, 30 Hz
// start frequency and its period; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module sine_sweep_pwm_generator #(
	parameter int POINTS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	sspg_stream_if.sink    item,
	sspg_stream_if.source  result,
	sspg_stream_if.sink    cfg
);
	localparam int TIME_W   = sspg_pkg::TIME_W;
	localparam int PERIOD_W = sspg_pkg::PERIOD_W;
	localparam int FREQ_W   = sspg_pkg::FREQ_W;
	localparam int IDX_W    = $clog2(POINTS);
	localparam int TGT_W    = PERIOD_W + IDX_W + 1;
	localparam int CMPT_W   = (TGT_W > TIME_W) ? TGT_W : TIME_W;
	localparam int SPAN_W   = PERIOD_W + $clog2(POINTS + 1);
	localparam int SW_W     = ((SPAN_W > TIME_W) ? SPAN_W : TIME_W) + 1;
	localparam int ROM_Q0   = sspg_pkg::ROM_DEPTH / POINTS;
	localparam int ROM_R0   = sspg_pkg::ROM_DEPTH % POINTS;
	localparam int PERIOD_RST_I = 1000000 / (POINTS * 30);
	localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(PERIOD_RST_I);
	localparam logic [SPAN_W-1:0]   SPAN_RST   = SPAN_W'(POINTS * PERIOD_RST_I);

	sspg_pkg::seq_state_t state_q, state_d;

	// configuration registers
	logic [FREQ_W-1:0]            fstart_q;
	logic [FREQ_W-1:0]            fend_q;
	logic [FREQ_W-1:0]            fstep_q;
	logic [sspg_pkg::LIMIT_W-1:0] limit_q;
	logic [sspg_pkg::RATE_W-1:0]  tick_half_q;

	// sweep state
	logic [IDX_W-1:0]               idx_q;
	logic [sspg_pkg::ROM_IDX_W-1:0] rom_q;
	logic [IDX_W-1:0]               rom_r_q;
	logic [TGT_W-1:0]               tgt_q;
	logic [TIME_W-1:0]              cyc_q;
	logic [TIME_W-1:0]              sweep_q;
	logic [FREQ_W-1:0]              freq_q;
	logic                           down_q;
	logic [PERIOD_W-1:0]            period_q;
	logic [SPAN_W-1:0]              span_q;
	logic [sspg_pkg::CMP_W-1:0]     pos_q;
	logic [sspg_pkg::CMP_W-1:0]     neg_q;
	logic                           updated_q;
	logic                           tick_q;

	// output register
	sspg_pkg::result_t res_q;
	logic              res_valid_q;
	logic              res_load;

	sspg_pkg::div_req_t div_req;
	sspg_pkg::div_rsp_t div_rsp;

	// point datapath
	logic [TIME_W:0]                  cyc_sum;
	logic [TIME_W-1:0]                cyc_new;
	logic                             hit;
	logic                             last_point;
	logic [TGT_W-1:0]                 tgt_next;
	logic [IDX_W:0]                   rom_r_sum;
	logic                             rom_carry;
	logic [sspg_pkg::SAMPLE_W-1:0]    sample;
	logic [sspg_pkg::CMP_W-1:0]       pos_new;
	logic [sspg_pkg::CMP_W-1:0]       neg_new;

	// sweep datapath
	logic [SW_W-1:0]   sw_sum;
	logic [TIME_W-1:0] sw_new;
	logic              step_due;

	// frequency step datapath
	logic signed [sspg_pkg::FSTEP_W-1:0] f_raw;
	logic signed [sspg_pkg::FSTEP_W-1:0] f_end_s;
	logic signed [sspg_pkg::FSTEP_W-1:0] f_start_s;
	logic [FREQ_W-1:0]                   f_next;
	logic                                down_next;

	sspg_divider #(
		.POINTS (POINTS)
	) u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// cycle clock advance and point instant check
	assign cyc_sum    = {1'b0, cyc_q} + (TIME_W + 1)'(tick_half_q);
	assign cyc_new    = cyc_sum[TIME_W] ? sspg_pkg::TIME_MAX : cyc_sum[TIME_W-1:0];
	assign hit        = CMPT_W'(cyc_new) >= CMPT_W'(tgt_q);
	assign last_point = idx_q == IDX_W'(POINTS - 1);
	assign tgt_next   = tgt_q + TGT_W'({period_q, 1'b0});

	// rom index tracks floor(k * 64 / POINTS) with a running remainder
	assign rom_r_sum = (IDX_W + 1)'(rom_r_q) + (IDX_W + 1)'(ROM_R0);
	assign rom_carry = rom_r_sum >= (IDX_W + 1)'(POINTS);

	// sample to compare pair
	assign sample = sspg_pkg::SINE_ROM[rom_q];
	always_comb begin
		if (sample > sspg_pkg::HALF_SCALE) begin
			pos_new = sspg_pkg::CMP_W'(sspg_pkg::FULL_SCALE - sample);
			neg_new = sspg_pkg::CMP_TOP;
		end else begin
			pos_new = '0;
			neg_new = sspg_pkg::CMP_W'(sspg_pkg::HALF_SCALE - sample);
		end
	end

	// saturating sweep time and update check
	assign sw_sum   = SW_W'(sweep_q) + SW_W'(span_q);
	assign sw_new   = (sw_sum > SW_W'(sspg_pkg::TIME_MAX)) ? sspg_pkg::TIME_MAX
	                                                       : sw_sum[TIME_W-1:0];
	assign step_due = sw_new >= TIME_W'(limit_q);

	// frequency step with clamp and turn at either end
	assign f_end_s   = $signed({2'b00, fend_q});
	assign f_start_s = $signed({2'b00, fstart_q});
	assign f_raw     = down_q ? ($signed({2'b00, freq_q}) - $signed({2'b00, fstep_q}))
	                          : ($signed({2'b00, freq_q}) + $signed({2'b00, fstep_q}));
	always_comb begin
		if (f_raw > f_end_s) begin
			f_next    = fend_q;
			down_next = 1'b1;
		end else if (f_raw < f_start_s) begin
			f_next    = fstart_q;
			down_next = 1'b0;
		end else begin
			f_next    = f_raw[FREQ_W-1:0];
			down_next = down_q;
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sspg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state and controls
	always_comb begin
		state_d       = state_q;
		item.ready    = 1'b0;
		div_req.start = 1'b0;
		div_req.freq  = f_next;
		res_load      = 1'b0;
		case (state_q)
			sspg_pkg::ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					state_d = sspg_pkg::ST_POINT;
				end
			end
			sspg_pkg::ST_POINT: begin
				if (tick_q && hit && last_point) begin
					state_d = sspg_pkg::ST_SWEEP;
				end else begin
					state_d = sspg_pkg::ST_PUSH;
				end
			end
			sspg_pkg::ST_SWEEP: begin
				state_d = step_due ? sspg_pkg::ST_STEP : sspg_pkg::ST_PUSH;
			end
			sspg_pkg::ST_STEP: begin
				div_req.start = 1'b1;
				state_d       = sspg_pkg::ST_DIV;
			end
			sspg_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = sspg_pkg::ST_SPAN;
				end
			end
			sspg_pkg::ST_SPAN: begin
				state_d = sspg_pkg::ST_PUSH;
			end
			sspg_pkg::ST_PUSH: begin
				if (!res_valid_q || result.ready) begin
					res_load = 1'b1;
					state_d  = sspg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sspg_pkg::ST_IDLE;
			end
		endcase
	end

	// input capture
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			tick_q <= item.data.tick;
		end
	end

	// configuration writes
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fstart_q    <= sspg_pkg::FREQ_START_RST;
			fend_q      <= sspg_pkg::FREQ_END_RST;
			fstep_q     <= sspg_pkg::FREQ_STEP_RST;
			limit_q     <= sspg_pkg::LIMIT_RST;
			tick_half_q <= sspg_pkg::TICK_RST;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				sspg_pkg::CFG_FREQ_START: begin
					fstart_q <= cfg.data.wdata[FREQ_W-1:0];
				end
				sspg_pkg::CFG_FREQ_END: begin
					fend_q <= cfg.data.wdata[FREQ_W-1:0];
				end
				sspg_pkg::CFG_FREQ_STEP: begin
					fstep_q <= cfg.data.wdata[FREQ_W-1:0];
				end
				sspg_pkg::CFG_UPDATE_INTERVAL: begin
					limit_q <= sspg_pkg::LIMIT_W'(cfg.data.wdata[sspg_pkg::RATE_W-1:0])
					           * sspg_pkg::US_PER_MS;
				end
				sspg_pkg::CFG_TICK_HALF_US: begin
					tick_half_q <= cfg.data.wdata[sspg_pkg::RATE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// sweep state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rom_q     <= '0;
			rom_r_q   <= '0;
			tgt_q     <= '0;
			cyc_q     <= '0;
			sweep_q   <= '0;
			freq_q    <= sspg_pkg::FREQ_START_RST;
			down_q    <= 1'b0;
			period_q  <= PERIOD_RST;
			span_q    <= SPAN_RST;
			pos_q     <= '0;
			neg_q     <= sspg_pkg::CMP_TOP;
			updated_q <= 1'b0;
		end else begin
			case (state_q)
				sspg_pkg::ST_POINT: begin
					updated_q <= tick_q && hit;
					if (tick_q) begin
						if (hit) begin
							pos_q <= pos_new;
							neg_q <= neg_new;
						end
						if (hit && last_point) begin
							idx_q   <= '0;
							rom_q   <= '0;
							rom_r_q <= '0;
							tgt_q   <= '0;
							cyc_q   <= '0;
						end else begin
							cyc_q <= cyc_new;
							if (hit) begin
								idx_q   <= idx_q + IDX_W'(1);
								tgt_q   <= tgt_next;
								rom_r_q <= rom_carry
								           ? IDX_W'(rom_r_sum - (IDX_W + 1)'(POINTS))
								           : rom_r_sum[IDX_W-1:0];
								rom_q   <= rom_q + sspg_pkg::ROM_IDX_W'(ROM_Q0)
								           + sspg_pkg::ROM_IDX_W'(rom_carry);
							end
						end
					end
				end
				sspg_pkg::ST_SWEEP: begin
					sweep_q <= step_due ? '0 : sw_new;
				end
				sspg_pkg::ST_STEP: begin
					freq_q <= f_next;
					down_q <= down_next;
				end
				sspg_pkg::ST_DIV: begin
					if (div_rsp.done) begin
						period_q <= div_rsp.quotient;
					end
				end
				sspg_pkg::ST_SPAN: begin
					span_q <= SPAN_W'(period_q) * SPAN_W'(POINTS);
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.pwm_positive_compare <= pos_q;
			res_q.pwm_negative_compare <= neg_q;
			res_q.sample_updated       <= updated_q;
			res_q.current_frequency    <= freq_q;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	// a transaction is never taken back to back, the sequencer is busy after it
	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("tick accepted while a previous one is in flight");

	// the divider only finishes while the sequencer waits for it
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == sspg_pkg::ST_DIV)
		else $error("divider finished outside the wait state");

	// a loaded result shows up on the result channel
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> result.valid)
		else $error("loaded result not presented");

	// point index stays inside one sine cycle
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_W'(POINTS - 1))
		else $error("point index past the end of the cycle");

endmodule
`default_nettype wire

// File: hw/rtl/sspg_divider.sv
// bit-serial restoring divider for the point period, 1000000 / (points * freq)
`timescale 1ns / 1ps
`default_nettype none
module sspg_divider #(
	parameter int POINTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sspg_pkg::div_req_t  req,
	output sspg_pkg::div_rsp_t  rsp
);
	localparam int MUL_W = $clog2(POINTS + 1);
	localparam int DIV_W = sspg_pkg::FREQ_W + MUL_W;
	localparam int CNT_W = $clog2(sspg_pkg::PERIOD_W);

	sspg_pkg::div_state_t state_q, state_d;

	logic [sspg_pkg::FREQ_W-1:0]   freq_q;
	logic [DIV_W-1:0]              divisor_q;
	logic [DIV_W-1:0]              rem_q;
	logic [sspg_pkg::PERIOD_W-1:0] num_q;
	logic [sspg_pkg::PERIOD_W-1:0] quo_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          done_q;
	logic                          done_d;

	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             fits;
	logic             last_bit;

	// one trial subtraction per cycle
	assign trial    = {rem_q, num_q[sspg_pkg::PERIOD_W-1]};
	assign diff     = trial - {1'b0, divisor_q};
	assign fits     = trial >= {1'b0, divisor_q};
	assign last_bit = cnt_q == CNT_W'(sspg_pkg::PERIOD_W - 1);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sspg_pkg::DV_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		case (state_q)
			sspg_pkg::DV_IDLE: begin
				if (req.start) begin
					state_d = sspg_pkg::DV_LOAD;
				end
			end
			sspg_pkg::DV_LOAD: begin
				state_d = sspg_pkg::DV_RUN;
			end
			sspg_pkg::DV_RUN: begin
				if (last_bit) begin
					state_d = sspg_pkg::DV_IDLE;
					done_d  = 1'b1;
				end
			end
			default: begin
				state_d = sspg_pkg::DV_IDLE;
			end
		endcase
	end

	// datapath: dividend shifts out msb first, quotient shifts in lsb
	always_ff @(posedge clk) begin
		case (state_q)
			sspg_pkg::DV_IDLE: begin
				if (req.start) begin
					freq_q <= req.freq;
				end
			end
			sspg_pkg::DV_LOAD: begin
				divisor_q <= DIV_W'(freq_q) * DIV_W'(POINTS);
				rem_q     <= '0;
				num_q     <= sspg_pkg::DIVIDEND;
				cnt_q     <= '0;
			end
			sspg_pkg::DV_RUN: begin
				rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
				num_q <= {num_q[sspg_pkg::PERIOD_W-2:0], 1'b0};
				quo_q <= {quo_q[sspg_pkg::PERIOD_W-2:0], fits};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// zero frequency gives a zero period
	assign rsp.done     = done_q;
	assign rsp.quotient = (divisor_q == '0) ? '0 : quo_q;

endmodule
`default_nettype wire
